FILE: hw/rtl/plist_pkg.sv
// Shared constants, codes and types for the positional list engine.
package plist_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FN_W     = 3;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int EC_W     = 6;
  localparam int ST_W     = 2;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [FN_W-1:0] FN_APPEND     = 3'd0;
  localparam logic [FN_W-1:0] FN_INSERT     = 3'd1;
  localparam logic [FN_W-1:0] FN_REMOVE_END = 3'd2;
  localparam logic [FN_W-1:0] FN_REMOVE_AT  = 3'd3;
  localparam logic [FN_W-1:0] FN_COUNT      = 3'd4;
  localparam logic [FN_W-1:0] FN_DUMP       = 3'd5;

  localparam logic [ST_W-1:0] STAT_OK     = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] STAT_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/plist_cell.sv
// One storage cell of the list chain: holds, loads, or takes a neighbor's or the head's entry.
module plist_cell (
  input  logic                                 clk,
  input  plist_pkg::cell_ctl_t                 ctl,
  input  logic [plist_pkg::IDX_W-1:0]          cell_idx,
  input  logic signed [plist_pkg::VAL_W-1:0]   wr_value,
  input  logic signed [plist_pkg::VAL_W-1:0]   left_value,
  input  logic signed [plist_pkg::VAL_W-1:0]   right_value,
  input  logic signed [plist_pkg::VAL_W-1:0]   head_value,
  output logic signed [plist_pkg::VAL_W-1:0]   value
);

  logic signed [plist_pkg::VAL_W-1:0] value_r;
  logic signed [plist_pkg::VAL_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    case (ctl.op)
      plist_pkg::CELL_INSERT: begin
        if (cell_idx == ctl.idx) begin
          value_nxt = wr_value;
        end else if (cell_idx > ctl.idx) begin
          value_nxt = left_value;
        end
      end
      plist_pkg::CELL_REMOVE: begin
        if (cell_idx >= ctl.idx) begin
          value_nxt = right_value;
        end
      end
      // idx is the tail: the head wraps around to it
      plist_pkg::CELL_ROTATE: begin
        if (cell_idx == ctl.idx) begin
          value_nxt = head_value;
        end else if (cell_idx < ctl.idx) begin
          value_nxt = right_value;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

FILE: hw/rtl/positional_list_engine_core.sv
// Top level of the positional list engine: control, output register and cell chain.
//
// Ordered list of up to CAPACITY signed 32-bit entries kept in a row of
// shifting cells, head in cell 0.
// Input channel (in_*): one item per operation: append, insert at a
// 1-based position, remove last, remove at position, count, dump.
// Result channel (out_*): one item per operation, or one per entry for a
// dump of a non-empty list, tlast set on the final item of the run.
// A single-item operation updates the cells and the output
// register in the accepting cycle; its result is valid in the next cycle.
// Throughput: one non-dump item per cycle while the result side takes
// items. A dump is accepted first and then sends the stored entries in
// list order, the list rotating through cell 0; no input is taken meanwhile.
// Receiver stall: the output register holds its item and in_tready drops
// until it is taken; a dump pauses its rotation.
// Reset (rst_n low, synchronous): the list is emptied and the output
// valid flag cleared. Entry cells are not reset; only cells below the
// count are ever read.
module positional_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[2:0], position[8:3], item_value[40:9], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_value[31:0], entry_count[37:32], status[39:38]
  output logic        out_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  localparam int IW = plist_pkg::IDX_W;
  localparam int CW = plist_pkg::CNT_W;
  localparam int MW = plist_pkg::CMP_W;
  localparam int VW = plist_pkg::VAL_W;
  localparam int EW = plist_pkg::EC_W;
  localparam int SW = plist_pkg::ST_W;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_value_r, out_value_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;
  logic [SW-1:0]        out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [plist_pkg::FN_W-1:0]  in_func;
  logic [plist_pkg::POS_W-1:0] in_pos;
  logic signed [VW-1:0]        in_value;

  logic                 slot_free;
  logic                 in_accept;
  logic                 is_full;
  logic                 is_empty;
  logic [MW-1:0]        pos_ext;
  logic [MW-1:0]        cnt_ext;
  logic [MW-1:0]        pos_m1;
  logic [CW-1:0]        tail_cnt;
  logic [CW+EW-1:0]     ec_wide;

  plist_pkg::cell_ctl_t ctl;
  logic signed [VW-1:0] cell_val [plist_pkg::CAPACITY];

  assign in_func  = in_tdata[2:0];
  assign in_pos   = in_tdata[8:3];
  assign in_value = in_tdata[40:9];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_accept = in_tvalid && in_tready;

  assign is_full  = (count_r == CW'(plist_pkg::CAPACITY));
  assign is_empty = (count_r == '0);
  assign pos_ext  = MW'(in_pos);
  assign cnt_ext  = MW'(count_r);
  assign pos_m1   = pos_ext - MW'(1);
  assign tail_cnt = count_r - CW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ctl.op         = plist_pkg::CELL_HOLD;
    ctl.idx        = '0;

    if (in_accept) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_status_nxt = plist_pkg::STAT_OK;
      out_last_nxt   = 1'b1;
      case (in_func)
        plist_pkg::FN_APPEND: begin
          if (is_full) begin
            out_status_nxt = plist_pkg::STAT_FULL;
          end else begin
            ctl.op    = plist_pkg::CELL_INSERT;
            ctl.idx   = count_r[IW-1:0];
            count_nxt = count_r + CW'(1);
          end
        end
        plist_pkg::FN_INSERT: begin
          if (is_full) begin
            out_status_nxt = plist_pkg::STAT_FULL;
          end else if (pos_ext == '0 || pos_ext > cnt_ext + MW'(1)) begin
            out_status_nxt = plist_pkg::STAT_BADPOS;
          end else begin
            ctl.op    = plist_pkg::CELL_INSERT;
            ctl.idx   = pos_m1[IW-1:0];
            count_nxt = count_r + CW'(1);
          end
        end
        plist_pkg::FN_REMOVE_END: begin
          if (is_empty) begin
            out_status_nxt = plist_pkg::STAT_EMPTY;
          end else begin
            ctl.op    = plist_pkg::CELL_REMOVE;
            ctl.idx   = tail_cnt[IW-1:0];
            count_nxt = tail_cnt;
          end
        end
        plist_pkg::FN_REMOVE_AT: begin
          if (is_empty) begin
            out_status_nxt = plist_pkg::STAT_EMPTY;
          end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
            out_status_nxt = plist_pkg::STAT_BADPOS;
          end else begin
            ctl.op    = plist_pkg::CELL_REMOVE;
            ctl.idx   = pos_m1[IW-1:0];
            count_nxt = tail_cnt;
          end
        end
        plist_pkg::FN_DUMP: begin
          if (is_empty) begin
            out_status_nxt = plist_pkg::STAT_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            rem_nxt       = count_r;
            state_nxt     = S_DUMP;
          end
        end
        default: ;
      endcase
      out_count_nxt = count_nxt;
    end else if (state_r == S_DUMP && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = cell_val[0];
      out_count_nxt  = count_r;
      out_status_nxt = plist_pkg::STAT_OK;
      out_last_nxt   = (rem_r == CW'(1));
      ctl.op         = plist_pkg::CELL_ROTATE;
      ctl.idx        = tail_cnt[IW-1:0];
      rem_nxt        = rem_r - CW'(1);
      if (rem_r == CW'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  genvar i;
  generate
    for (i = 0; i < plist_pkg::CAPACITY; i++) begin : g_cell
      logic signed [VW-1:0] left_v;
      logic signed [VW-1:0] right_v;
      if (i == 0) begin : g_first
        assign left_v = in_value;
      end else begin : g_mid_l
        assign left_v = cell_val[i-1];
      end
      if (i == plist_pkg::CAPACITY - 1) begin : g_last
        assign right_v = cell_val[i];
      end else begin : g_mid_r
        assign right_v = cell_val[i+1];
      end
      plist_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .cell_idx    (IW'(i)),
        .wr_value    (in_value),
        .left_value  (left_v),
        .right_value (right_v),
        .head_value  (cell_val[0]),
        .value       (cell_val[i])
      );
    end
  endgenerate

  assign ec_wide    = {{EW{1'b0}}, out_count_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_status_r, ec_wide[EW-1:0], out_value_r};
  assign out_tlast  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(plist_pkg::CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> rem_r != '0 && rem_r <= count_r)
    else $error("dump run counter out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_func != plist_pkg::FN_DUMP |=> out_tvalid && out_tlast)
    else $error("single-item operation gave no final result");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_func == plist_pkg::FN_COUNT |=> $stable(count_r))
    else $error("count request changed the list");

endmodule
